@@ src/trf_pkg.sv @@
// shared types and constants for the tiered rational fee block
package trf_pkg;

    localparam int BYTES_W = 24;
    localparam int WORD_W  = 64;
    localparam int IDX_W   = 3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [IDX_W-1:0] CFG_PRICE_NUM  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PRICE_DEN  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_STRIDE     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_GROWTH_NUM = 3'd3;
    localparam logic [IDX_W-1:0] CFG_GROWTH_DEN = 3'd4;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_GCD_CHK,
        S_GCD_DIV,
        S_RED_NUM,
        S_RED_DEN,
        S_EX_INIT,
        S_EX_MULP,
        S_EX_DIVP,
        S_EX_ACC,
        S_EX_GNUM,
        S_EX_GDEN,
        S_EX_GREM,
        S_EX_END,
        S_HALVE,
        S_RND_INIT,
        S_RND_MUL,
        S_RND_GMUL,
        S_RND_GDIV,
        S_FIN,
        S_OUT
    } t_state;

endpackage

@@ src/tiered_rational_fee.sv @@
// tiered rational fee: sequencer, registers and stream ports around the shared alu
// usage:
//   config channel (i_cfg_*), always ready, writes the five price registers by
//   index; the user must write only while idle, the block does not enforce it.
//   index 0 price numerator, 1 price denominator, 2 tier stride, 3 growth
//   numerator, 4 growth denominator. slave stream carries one byte count per
//   beat; the block takes a beat only when idle, then computes with o_s_tready low.
//   master stream returns one beat per item: fee in tdata, status in tuser.
// every multiply or divide runs on one shared bit-serial unit:
//   gcd reduction costs up to about 93 divides plus two more; each tier of the
//   exact pass costs five ops, the rounded pass three ops per tier.
//   overflow adds one exact pass per halving step plus a rounded pass.
//   a zero byte count or zero denominator goes straight to the output state.
// reset sets the config registers to their defaults and drops all valids.
// a stalled master holds the result beat; the block stays busy until it is taken
// or it moves into the output register.
module tiered_rational_fee
    import trf_pkg::*;
#(
    parameter int SIZE_BITS = 24
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [WORD_W-1:0]  i_cfg_data,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [BYTES_W-1:0] i_s_tdata,   // [23:0] total_bytes
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [WORD_W-1:0]  o_m_tdata,   // [63:0] fee_amount
    output logic [1:0]         o_m_tuser    // [1:0] status_code
);

    localparam int UsedBits = (SIZE_BITS < BYTES_W) ? SIZE_BITS : BYTES_W;

    // configuration
    logic [WORD_W-1:0] r_pnum, r_pden;
    logic [31:0]       r_stride;
    logic [15:0]       r_gnum, r_gden;

    t_state            r_state, n_state;
    logic              r_issued, n_issued;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [BYTES_W-1:0] r_left, n_left;
    logic [WORD_W-1:0] r_ga, n_ga, r_gb, n_gb;
    logic [WORD_W-1:0] r_num, n_num, r_den, n_den;
    logic [WORD_W-1:0] r_en, n_en, r_ed, n_ed;
    logic [WORD_W-1:0] r_whole, n_whole, r_rem, n_rem;
    logic [WORD_W-1:0] r_price, n_price, r_trem, n_trem;
    logic [WORD_W-1:0] r_hnum, n_hnum, r_hden, n_hden;
    logic [WORD_W-1:0] r_hfee, n_hfee, r_rprice, n_rprice, r_total, n_total;
    logic [WORD_W-1:0] r_fee, n_fee;
    logic [1:0]        r_status, n_status;
    logic              r_hok, n_hok, r_rok, n_rok, r_mode, n_mode, r_exok, n_exok;
    logic              r_ovalid, n_ovalid;
    logic [WORD_W-1:0] r_ofee, n_ofee;
    logic [1:0]        r_ostat, n_ostat;

    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    logic [WORD_W-1:0] alu_a, alu_b, alu_q, alu_r;
    logic              op_state;

    logic [31:0]        eff_stride;
    logic [15:0]        eff_gden;
    logic [BYTES_W-1:0] sz, left_nx;
    logic [BYTES_W-1:0] in_bytes;
    logic               s_acc;
    logic [WORD_W:0]    whole_q, whole_1, total_q;
    logic [WORD_W-1:0]  lim, ceil_q, hnum_h;
    logic               rem_ge, out_free;

    assign eff_stride = (r_stride == 32'd0) ? 32'd1 : r_stride;
    assign eff_gden   = (r_gden == 16'd0) ? 16'd1 : r_gden;
    assign sz         = ({8'd0, r_left} < eff_stride) ? r_left : eff_stride[BYTES_W-1:0];
    assign left_nx    = r_left - sz;
    assign in_bytes   = BYTES_W'(i_s_tdata[UsedBits-1:0]);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign whole_q    = {1'b0, r_whole} + {1'b0, alu_q};
    assign whole_1    = {1'b0, r_whole} + 65'd1;
    assign total_q    = {1'b0, r_total} + {1'b0, alu_q};
    assign lim        = r_ed - r_trem;
    assign rem_ge     = r_rem >= lim;
    assign ceil_q     = alu_q + ((alu_r != '0) ? 64'd1 : 64'd0);
    assign hnum_h     = (r_hnum >> 1) + {63'd0, r_hnum[0]};
    assign out_free   = !r_ovalid || i_m_tready;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_ofee;
    assign o_m_tuser   = r_ostat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pnum   <= '0;
            r_pden   <= 64'd1;
            r_stride <= 32'd25600;
            r_gnum   <= 16'd6;
            r_gden   <= 16'd5;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PRICE_NUM:  r_pnum   <= i_cfg_data;
                CFG_PRICE_DEN:  r_pden   <= i_cfg_data;
                CFG_STRIDE:     r_stride <= i_cfg_data[31:0];
                CFG_GROWTH_NUM: r_gnum   <= i_cfg_data[15:0];
                CFG_GROWTH_DEN: r_gden   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    trf_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_rsp   (alu_rsp),
        .o_q     (alu_q),
        .o_r     (alu_r)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (in_bytes == '0 || r_pden == '0) n_state = S_OUT;
                    else n_state = S_GCD_CHK;
                end
            end
            S_GCD_CHK:  n_state = (r_gb == '0) ? S_RED_NUM : S_GCD_DIV;
            S_GCD_DIV:  if (alu_rsp.done) n_state = S_GCD_CHK;
            S_RED_NUM:  if (alu_rsp.done) n_state = S_RED_DEN;
            S_RED_DEN:  if (alu_rsp.done) n_state = S_EX_INIT;
            S_EX_INIT:  n_state = S_EX_MULP;
            S_EX_MULP:  if (alu_rsp.done) n_state = alu_rsp.ovf ? S_EX_END : S_EX_DIVP;
            S_EX_DIVP:  if (alu_rsp.done) n_state = whole_q[WORD_W] ? S_EX_END : S_EX_ACC;
            S_EX_ACC: begin
                if (rem_ge && whole_1[WORD_W]) n_state = S_EX_END;
                else if (left_nx != '0) n_state = S_EX_GNUM;
                else n_state = S_EX_END;
            end
            S_EX_GNUM:  if (alu_rsp.done) n_state = alu_rsp.ovf ? S_EX_END : S_EX_GDEN;
            S_EX_GDEN:  if (alu_rsp.done) n_state = alu_rsp.ovf ? S_EX_END : S_EX_GREM;
            S_EX_GREM:  if (alu_rsp.done) n_state = S_EX_MULP;
            S_EX_END: begin
                if (r_exok) n_state = r_mode ? S_RND_INIT : S_OUT;
                else n_state = S_HALVE;
            end
            S_HALVE:    n_state = (r_hden > 64'd1) ? S_EX_INIT : S_RND_INIT;
            S_RND_INIT: if (alu_rsp.done) n_state = S_RND_MUL;
            S_RND_MUL: begin
                if (alu_rsp.done) begin
                    if (alu_rsp.ovf || total_q[WORD_W] || left_nx == '0) n_state = S_FIN;
                    else n_state = S_RND_GMUL;
                end
            end
            S_RND_GMUL: if (alu_rsp.done) n_state = alu_rsp.ovf ? S_FIN : S_RND_GDIV;
            S_RND_GDIV: if (alu_rsp.done) n_state = S_RND_MUL;
            S_FIN:      n_state = S_OUT;
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // alu requests
    always_comb begin
        op_state = 1'b1;
        alu_req.op = ALU_DIV;
        alu_a = r_ga;
        alu_b = r_gb;
        case (r_state)
            S_GCD_DIV: ;
            S_RED_NUM:  begin alu_a = r_pnum; alu_b = r_ga; end
            S_RED_DEN:  begin alu_a = r_pden; alu_b = r_ga; end
            S_EX_MULP:  begin alu_req.op = ALU_MUL; alu_a = 64'(sz); alu_b = r_en; end
            S_EX_DIVP:  begin alu_a = r_price; alu_b = r_ed; end
            S_EX_GNUM:  begin alu_req.op = ALU_MUL; alu_a = r_en; alu_b = 64'(r_gnum); end
            S_EX_GDEN:  begin alu_req.op = ALU_MUL; alu_a = r_ed; alu_b = 64'(eff_gden); end
            S_EX_GREM:  begin alu_req.op = ALU_MUL; alu_a = r_rem; alu_b = 64'(eff_gden); end
            S_RND_INIT: begin alu_a = r_num; alu_b = r_den; end
            S_RND_MUL:  begin alu_req.op = ALU_MUL; alu_a = 64'(sz); alu_b = r_rprice; end
            S_RND_GMUL: begin alu_req.op = ALU_MUL; alu_a = r_rprice; alu_b = 64'(r_gnum); end
            S_RND_GDIV: begin alu_a = r_rprice; alu_b = 64'(eff_gden); end
            default:    op_state = 1'b0;
        endcase
        alu_req.start = op_state && !r_issued && !alu_rsp.done;
    end

    // datapath
    always_comb begin
        n_issued = r_issued;
        n_bytes = r_bytes;   n_left = r_left;
        n_ga = r_ga;         n_gb = r_gb;
        n_num = r_num;       n_den = r_den;
        n_en = r_en;         n_ed = r_ed;
        n_whole = r_whole;   n_rem = r_rem;
        n_price = r_price;   n_trem = r_trem;
        n_hnum = r_hnum;     n_hden = r_hden;
        n_hfee = r_hfee;     n_rprice = r_rprice;
        n_total = r_total;   n_fee = r_fee;
        n_status = r_status; n_hok = r_hok;
        n_rok = r_rok;       n_mode = r_mode;
        n_exok = r_exok;
        n_ovalid = r_ovalid; n_ofee = r_ofee; n_ostat = r_ostat;

        if (alu_req.start) n_issued = 1'b1;
        if (alu_rsp.done)  n_issued = 1'b0;
        if (r_ovalid && i_m_tready) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_bytes  = in_bytes;
                    n_fee    = '0;
                    n_status = (in_bytes != '0 && r_pden == '0) ? ST_INVALID : ST_OK;
                    n_ga     = r_pnum;
                    n_gb     = r_pden;
                    n_hok    = 1'b0;
                    n_rok    = 1'b0;
                    n_mode   = 1'b0;
                end
            end
            S_GCD_DIV: if (alu_rsp.done) begin n_ga = r_gb; n_gb = alu_r; end
            S_RED_NUM: if (alu_rsp.done) begin n_num = alu_q; n_en = alu_q; end
            S_RED_DEN: if (alu_rsp.done) begin n_den = alu_q; n_ed = alu_q; end
            S_EX_INIT: begin
                n_whole = '0;
                n_rem   = '0;
                n_left  = r_bytes;
                n_exok  = 1'b0;
            end
            S_EX_MULP: if (alu_rsp.done) n_price = alu_q;
            S_EX_DIVP: if (alu_rsp.done) begin
                n_whole = whole_q[WORD_W-1:0];
                n_trem  = alu_r;
            end
            S_EX_ACC: begin
                if (rem_ge) begin
                    n_rem   = r_rem - lim;
                    n_whole = whole_1[WORD_W-1:0];
                end else begin
                    n_rem = r_rem + r_trem;
                end
                n_left = left_nx;
                n_exok = !(rem_ge && whole_1[WORD_W]) && (left_nx == '0);
            end
            S_EX_GNUM: if (alu_rsp.done) n_en = alu_q;
            S_EX_GDEN: if (alu_rsp.done) n_ed = alu_q;
            S_EX_GREM: if (alu_rsp.done) n_rem = alu_q;
            S_EX_END: begin
                if (r_exok) begin
                    if (r_mode) begin
                        n_hok  = 1'b1;
                        n_hfee = r_whole;
                    end else begin
                        n_fee = r_whole;
                    end
                end else if (!r_mode) begin
                    n_hnum = r_num;
                    n_hden = r_den;
                end
            end
            S_HALVE: begin
                if (r_hden > 64'd1) begin
                    n_hnum = hnum_h;
                    n_hden = r_hden >> 1;
                    n_en   = hnum_h;
                    n_ed   = r_hden >> 1;
                    n_mode = 1'b1;
                end
            end
            S_RND_INIT: if (alu_rsp.done) begin
                n_rprice = ceil_q;
                n_total  = '0;
                n_left   = r_bytes;
            end
            S_RND_MUL: if (alu_rsp.done) begin
                n_total = total_q[WORD_W-1:0];
                n_left  = left_nx;
                n_rok   = !alu_rsp.ovf && !total_q[WORD_W] && (left_nx == '0);
            end
            S_RND_GMUL: if (alu_rsp.done) n_rprice = alu_q;
            S_RND_GDIV: if (alu_rsp.done) n_rprice = ceil_q;
            S_FIN: begin
                if (r_hok && r_rok) n_fee = (r_hfee < r_total) ? r_hfee : r_total;
                else if (r_hok) n_fee = r_hfee;
                else if (r_rok) n_fee = r_total;
                else begin
                    n_fee    = '0;
                    n_status = ST_OVERFLOW;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ofee   = r_fee;
                    n_ostat  = r_status;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_ovalid <= n_ovalid;
        end
        r_bytes <= n_bytes;   r_left <= n_left;
        r_ga <= n_ga;         r_gb <= n_gb;
        r_num <= n_num;       r_den <= n_den;
        r_en <= n_en;         r_ed <= n_ed;
        r_whole <= n_whole;   r_rem <= n_rem;
        r_price <= n_price;   r_trem <= n_trem;
        r_hnum <= n_hnum;     r_hden <= n_hden;
        r_hfee <= n_hfee;     r_rprice <= n_rprice;
        r_total <= n_total;   r_fee <= n_fee;
        r_status <= n_status; r_hok <= n_hok;
        r_rok <= n_rok;       r_mode <= n_mode;
        r_exok <= n_exok;
        r_ofee <= n_ofee;     r_ostat <= n_ostat;
    end

`ifndef SYNTH
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == ST_OK || o_m_tuser == ST_INVALID ||
                        o_m_tuser == ST_OVERFLOW))
        else $error("bad status code");
    a_fee_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_OK) |-> (o_m_tdata == '0))
        else $error("nonzero fee with error status");
    a_issue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issued |-> op_state)
        else $error("alu op pending outside an op state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("accepted while busy");
`endif

endmodule

@@ src/trf_alu.sv @@
// shared bit-serial 64-bit multiplier with overflow flag and restoring divider
module trf_alu
    import trf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_req          i_req,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output t_alu_rsp          o_rsp,
    output logic [WORD_W-1:0] o_q,
    output logic [WORD_W-1:0] o_r
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [5:0]        r_cnt, n_cnt;
    t_alu_op           r_op, n_op;
    logic [WORD_W-1:0] r_a, n_a;
    logic [WORD_W-1:0] r_b, n_b;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic              r_ovf, n_ovf;

    logic [WORD_W:0]   mul_sum;
    logic [WORD_W:0]   rem_sh;
    logic              rem_ge;

    // multiplier walks the b operand msb first
    assign mul_sum = {1'b0, r_acc[WORD_W-2:0], 1'b0} + {1'b0, (r_b[WORD_W-1] ? r_a : '0)};
    assign rem_sh  = {r_rem, r_a[WORD_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_b};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_ovf  = r_ovf;
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy = 1'b1;
                n_cnt  = '0;
                n_op   = i_req.op;
                n_a    = i_a;
                n_b    = i_b;
                n_acc  = '0;
                n_rem  = '0;
                n_ovf  = 1'b0;
            end
        end else begin
            if (r_op == ALU_MUL) begin
                n_acc = mul_sum[WORD_W-1:0];
                n_ovf = r_ovf | r_acc[WORD_W-1] | mul_sum[WORD_W];
                n_b   = {r_b[WORD_W-2:0], 1'b0};
            end else begin
                if (rem_ge) begin
                    n_rem = WORD_W'(rem_sh - {1'b0, r_b});
                end else begin
                    n_rem = rem_sh[WORD_W-1:0];
                end
                n_a = {r_a[WORD_W-2:0], rem_ge};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_ovf <= n_ovf;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = (r_op == ALU_MUL) ? r_ovf : 1'b0;
    assign o_q        = (r_op == ALU_MUL) ? r_acc : r_a;
    assign o_r        = r_rem;

endmodule
